@@ hdl/ktw_pkg.sv @@
package ktw_pkg;

   localparam int GLYPH_DEPTH_DEF = 128;
   localparam int KERN_DEPTH_DEF  = 128;

   localparam logic [1:0] FUNC_GLYPH = 2'd0;
   localparam logic [1:0] FUNC_KERN  = 2'd1;
   localparam logic [1:0] FUNC_TEXT  = 2'd2;
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   localparam logic [15:0] CODE_QMARK = 16'h003F;

   localparam logic signed [19:0] TOTAL_MAX = 20'sh7FFFF;
   localparam logic signed [19:0] TOTAL_MIN = -20'sh80000;

   localparam logic [1:0] REG_GLYPHS = 2'd0;
   localparam logic [1:0] REG_KERNS  = 2'd1;

   // work for the back end: glyph advance of a, then optional kern a,b
   typedef struct packed {
      logic [15:0] code_a;
      logic [15:0] code_b;
      logic        do_kern;
      logic        emit;
      logic        has_a;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_GSRCH, ST_GREAD, ST_KSRCH, ST_KREAD, ST_OUT
   } state_type;

   // decoder steps for one text byte
   typedef enum logic [1:0] {
      PH_BREAK, PH_DECODE, PH_FLUSH, PH_FINISH
   } phase_type;

endpackage

@@ hdl/ktw_if.sv @@
interface ktw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [7:0]  entry_index;
   logic [15:0] code_a;
   logic [15:0] code_b;
   logic [7:0]  glyph_advance;
   logic signed [7:0] kern_adjust;
   logic [7:0]  text_byte;
   logic        last_byte;
   modport source (output valid, func, entry_index, code_a, code_b, glyph_advance,
                   kern_adjust, text_byte, last_byte, input ready);
   modport sink (input valid, func, entry_index, code_a, code_b, glyph_advance,
                 kern_adjust, text_byte, last_byte, output ready);
endinterface

interface ktw_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_width;
   modport source (output valid, text_width, input ready);
   modport sink (input valid, text_width, output ready);
endinterface

@@ hdl/ktw_front.sv @@
// Decodes UTF-8 and turns each text byte into at most two back-end jobs, the last byte into at most three.
module ktw_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   output logic              job_valid,
   input  logic              job_ready,
   output ktw_pkg::job_type  job
);
   logic [15:0] part_ff, part_in;
   logic [1:0]  left_ff, left_in;
   logic [15:0] pend_ff, pend_in;
   logic        pv_ff, pv_in, ended_ff, ended_in;
   logic        busy_ff, busy_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   ktw_pkg::phase_type phase_ff, phase_in;
   logic        jv_ff, jv_in;
   ktw_pkg::job_type job_ff, job_in;

   assign in_ready  = !busy_ff;
   assign job_valid = jv_ff;
   assign job       = job_ff;

   // break: '?' for a broken sequence; decode: the byte itself; flush/finish: end of text
   always_comb begin
      logic        have;
      logic [15:0] code;
      logic        cont;
      part_in = part_ff; left_in = left_ff; pend_in = pend_ff; pv_in = pv_ff;
      ended_in = ended_ff; busy_in = busy_ff; byte_in = byte_ff; last_in = last_ff;
      phase_in = phase_ff; jv_in = jv_ff; job_in = job_ff;
      have = 1'b0; code = 16'd0;
      cont = (byte_ff[7:6] == 2'b10);
      if (jv_ff && job_ready) jv_in = 1'b0;
      if (in_valid && !busy_ff) begin
         busy_in = 1'b1; byte_in = in_byte; last_in = in_last;
         phase_in = ktw_pkg::PH_BREAK;
      end else if (busy_ff && !(jv_ff && !job_ready)) begin
         job_in = '0;
         unique case (phase_ff)
            ktw_pkg::PH_BREAK: begin
               phase_in = ktw_pkg::PH_DECODE;
               if (left_ff != 2'd0 && !cont) begin
                  left_in = 2'd0; part_in = 16'd0;
                  have = 1'b1; code = ktw_pkg::CODE_QMARK;
               end
            end
            ktw_pkg::PH_DECODE: begin
               phase_in = ktw_pkg::PH_FLUSH;
               if (left_ff != 2'd0) begin
                  part_in = {part_ff[9:0], byte_ff[5:0]};
                  left_in = left_ff - 2'd1;
                  if (left_ff == 2'd1) begin
                     have = 1'b1; code = {part_ff[9:0], byte_ff[5:0]};
                  end
               end else if (!byte_ff[7]) begin
                  have = 1'b1; code = {8'd0, byte_ff};
               end else if (byte_ff[7:5] == 3'b110) begin
                  part_in = {11'd0, byte_ff[4:0]}; left_in = 2'd1;
               end else if (byte_ff[7:4] == 4'b1110) begin
                  part_in = {12'd0, byte_ff[3:0]}; left_in = 2'd2;
               end else begin
                  have = 1'b1; code = ktw_pkg::CODE_QMARK;
               end
               if (!last_ff) begin
                  busy_in = 1'b0; phase_in = ktw_pkg::PH_BREAK;
               end
            end
            default: begin
               if (left_ff != 2'd0) begin
                  left_in = 2'd0; part_in = 16'd0;
                  have = 1'b1; code = ktw_pkg::CODE_QMARK;
                  phase_in = ktw_pkg::PH_FINISH;
               end else begin
                  job_in.emit = 1'b1;
                  job_in.has_a = pv_ff && !ended_ff;
                  job_in.code_a = pend_ff;
                  jv_in = 1'b1;
                  part_in = 16'd0; left_in = 2'd0; pend_in = 16'd0;
                  pv_in = 1'b0; ended_in = 1'b0; busy_in = 1'b0;
                  phase_in = ktw_pkg::PH_BREAK;
               end
            end
         endcase
         if (have && !ended_ff) begin
            if (code == 16'd0) begin
               if (pv_ff) begin
                  job_in.has_a = 1'b1; job_in.code_a = pend_ff; jv_in = 1'b1;
               end
               pv_in = 1'b0; ended_in = 1'b1;
            end else begin
               if (pv_ff) begin
                  job_in.has_a = 1'b1; job_in.do_kern = 1'b1;
                  job_in.code_a = pend_ff; job_in.code_b = code; jv_in = 1'b1;
               end
               pend_in = code; pv_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_ff <= '0; left_ff <= '0; pend_ff <= '0; pv_ff <= 1'b0;
         ended_ff <= 1'b0; busy_ff <= 1'b0; phase_ff <= ktw_pkg::PH_BREAK; jv_ff <= 1'b0;
      end else begin
         part_ff <= part_in; left_ff <= left_in; pend_ff <= pend_in; pv_ff <= pv_in;
         ended_ff <= ended_in; busy_ff <= busy_in; phase_ff <= phase_in; jv_ff <= jv_in;
      end
      byte_ff <= byte_in; last_ff <= last_in; job_ff <= job_in;
   end
endmodule

@@ hdl/ktw_queue.sv @@
// Two-entry job FIFO between decoder and lookup engine.
module ktw_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  ktw_pkg::job_type wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output ktw_pkg::job_type rd_data
);
   ktw_pkg::job_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic wr, rd;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= !wp_ff;
         if (rd) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
      if (wr) mem_ff[wp_ff] <= wr_data;
   end
endmodule

@@ hdl/ktw_back.sv @@
// Binary-searches the glyph and kerning tables and accumulates the width.
module ktw_back #(
   parameter int GLYPH_DEPTH = ktw_pkg::GLYPH_DEPTH_DEF,
   parameter int KERN_DEPTH  = ktw_pkg::KERN_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             load_glyph,
   input  logic             load_kern,
   input  logic [7:0]       load_index,
   input  logic [15:0]      load_a,
   input  logic [15:0]      load_b,
   input  logic [7:0]       load_adv,
   input  logic [7:0]       load_adj,
   input  logic [7:0]       glyphs_in_use,
   input  logic [7:0]       kerns_in_use,
   input  logic             job_valid,
   output logic             job_ready,
   input  ktw_pkg::job_type job,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [7:0]       out_width
);
   localparam int GW = (GLYPH_DEPTH > 1) ? $clog2(GLYPH_DEPTH) : 1;
   localparam int KW = (KERN_DEPTH > 1) ? $clog2(KERN_DEPTH) : 1;
   localparam logic [8:0] GD = 9'(GLYPH_DEPTH);
   localparam logic [8:0] KD = 9'(KERN_DEPTH);

   logic [23:0] gmem [GLYPH_DEPTH];
   logic [39:0] kmem [KERN_DEPTH];
   logic [23:0] grd_ff;
   logic [39:0] krd_ff;

   ktw_pkg::state_type st_ff, st_in;
   ktw_pkg::job_type   cur_ff, cur_in;
   logic [8:0] lo_ff, lo_in, hi_ff, hi_in;
   logic signed [19:0] tot_ff, tot_in;
   logic       ov_ff, ov_in;
   logic [7:0] w_ff, w_in;
   logic [8:0] mid;
   logic [8:0] gcnt, kcnt;

   assign gcnt = ({1'b0, glyphs_in_use} < GD) ? {1'b0, glyphs_in_use} : GD;
   assign kcnt = ({1'b0, kerns_in_use} < KD) ? {1'b0, kerns_in_use} : KD;
   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);

   always_ff @(posedge clock) begin
      if (load_glyph && {1'b0, load_index} < GD)
         gmem[load_index[GW-1:0]] <= {load_a, load_adv};
      if (load_kern && {1'b0, load_index} < KD)
         kmem[load_index[KW-1:0]] <= {load_a, load_b, load_adj};
      grd_ff <= gmem[mid[GW-1:0]];
      krd_ff <= kmem[mid[KW-1:0]];
   end

   function automatic logic signed [19:0] sat_add(logic signed [19:0] t,
                                                 logic signed [19:0] v);
      logic signed [20:0] s;
      s = 21'(t) + 21'(v);
      if (s > 21'(ktw_pkg::TOTAL_MAX)) return ktw_pkg::TOTAL_MAX;
      if (s < 21'(ktw_pkg::TOTAL_MIN)) return ktw_pkg::TOTAL_MIN;
      return s[19:0];
   endfunction

   assign job_ready = (st_ff == ktw_pkg::ST_IDLE);
   assign out_valid = ov_ff;
   assign out_width = w_ff;

   always_comb begin
      logic lt, gt;
      st_in = st_ff; cur_in = cur_ff; lo_in = lo_ff; hi_in = hi_ff;
      tot_in = tot_ff; ov_in = ov_ff; w_in = w_ff;
      lt = 1'b0; gt = 1'b0;
      if (ov_ff && out_ready) ov_in = 1'b0;
      unique case (st_ff)
         ktw_pkg::ST_IDLE: begin
            if (job_valid) begin
               cur_in = job; lo_in = 9'd0; hi_in = gcnt;
               st_in = job.has_a ? ktw_pkg::ST_GSRCH : ktw_pkg::ST_OUT;
            end
         end
         ktw_pkg::ST_GSRCH: begin
            if (lo_ff < hi_ff) st_in = ktw_pkg::ST_GREAD;
            else begin
               lo_in = 9'd0; hi_in = kcnt;
               st_in = cur_ff.do_kern ? ktw_pkg::ST_KSRCH : ktw_pkg::ST_OUT;
            end
         end
         ktw_pkg::ST_GREAD: begin
            st_in = ktw_pkg::ST_GSRCH;
            if (grd_ff[23:8] < cur_ff.code_a) lo_in = mid + 9'd1;
            else if (grd_ff[23:8] > cur_ff.code_a) hi_in = mid;
            else begin
               tot_in = sat_add(tot_ff, 20'(grd_ff[7:0]));
               lo_in = 9'd0; hi_in = kcnt;
               st_in = cur_ff.do_kern ? ktw_pkg::ST_KSRCH : ktw_pkg::ST_OUT;
            end
         end
         ktw_pkg::ST_KSRCH: begin
            st_in = (lo_ff < hi_ff) ? ktw_pkg::ST_KREAD : ktw_pkg::ST_OUT;
         end
         ktw_pkg::ST_KREAD: begin
            lt = krd_ff[39:24] < cur_ff.code_a ||
                 (krd_ff[39:24] == cur_ff.code_a && krd_ff[23:8] < cur_ff.code_b);
            gt = krd_ff[39:24] > cur_ff.code_a || krd_ff[23:8] > cur_ff.code_b;
            st_in = ktw_pkg::ST_KSRCH;
            if (lt) lo_in = mid + 9'd1;
            else if (gt) hi_in = mid;
            else begin
               tot_in = sat_add(tot_ff, 20'(signed'(krd_ff[7:0])));
               st_in = ktw_pkg::ST_OUT;
            end
         end
         default: begin
            if (!cur_ff.emit) st_in = ktw_pkg::ST_IDLE;
            else if (!ov_ff || out_ready) begin
               ov_in = 1'b1;
               w_in = tot_ff[19] ? 8'd0 : ((tot_ff > 20'sd255) ? 8'hFF : tot_ff[7:0]);
               tot_in = '0;
               st_in = ktw_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ktw_pkg::ST_IDLE; tot_ff <= '0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; tot_ff <= tot_in; ov_ff <= ov_in;
      end
      cur_ff <= cur_in; lo_ff <= lo_in; hi_ff <= hi_in; w_ff <= w_in;
   end
endmodule

@@ hdl/kerned_text_width_measure_unit.sv @@
// Flow: a text byte is taken, then passes the decoder's break and decode steps; the decoder
// takes no new byte until it is through with the last. The last byte adds a flush step
// (and a finish step for a cut sequence). Each code point job runs a glyph and a kern search
// of up to 8 probes each at depth 128 (a search and a read state per probe) and a finish state.
// Width: rsp valid once the last byte's final job has passed the lookup engine; loads are
// taken once nothing is in flight.
// Reset: synchronous, active high; clears control, counts and total, tables keep data.
module kerned_text_width_measure_unit #(
   parameter int GLYPH_DEPTH = ktw_pkg::GLYPH_DEPTH_DEF,
   parameter int KERN_DEPTH  = ktw_pkg::KERN_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ktw_req_if.sink     req,
   ktw_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [7:0] glyphs_ff, kerns_ff;
   logic wr;
   logic is_text, is_load, idle, f_ready, f_valid;
   logic jv, jr, qv, qr;
   ktw_pkg::job_type fj, qj;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         glyphs_ff <= '0; kerns_ff <= '0;
      end else if (wr) begin
         if (csr_paddr[2] == ktw_pkg::REG_GLYPHS[0]) glyphs_ff <= csr_pwdata[7:0];
         else kerns_ff <= csr_pwdata[7:0];
      end
   end
   assign csr_prdata = (csr_paddr[2] == ktw_pkg::REG_GLYPHS[0]) ? {24'd0, glyphs_ff}
                                                                 : {24'd0, kerns_ff};

   assign is_text = (req.func == ktw_pkg::FUNC_TEXT);
   assign is_load = (req.func == ktw_pkg::FUNC_GLYPH) || (req.func == ktw_pkg::FUNC_KERN);
   // hold a table load until every earlier text byte has been looked up
   assign idle    = f_ready && !jv && !qv && qr;
   assign f_valid = req.valid && is_text;
   assign req.ready = is_text ? f_ready : (is_load ? idle : 1'b1);

   ktw_front u_front (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready),
      .in_byte(req.text_byte), .in_last(req.last_byte),
      .job_valid(jv), .job_ready(jr), .job(fj)
   );

   ktw_queue u_queue (
      .clock, .reset, .wr_valid(jv), .wr_ready(jr), .wr_data(fj),
      .rd_valid(qv), .rd_ready(qr), .rd_data(qj)
   );

   ktw_back #(.GLYPH_DEPTH(GLYPH_DEPTH), .KERN_DEPTH(KERN_DEPTH)) u_back (
      .clock, .reset,
      .load_glyph(req.valid && idle && req.func == ktw_pkg::FUNC_GLYPH),
      .load_kern(req.valid && idle && req.func == ktw_pkg::FUNC_KERN),
      .load_index(req.entry_index), .load_a(req.code_a), .load_b(req.code_b),
      .load_adv(req.glyph_advance), .load_adj(req.kern_adjust),
      .glyphs_in_use(glyphs_ff), .kerns_in_use(kerns_ff),
      .job_valid(qv), .job_ready(qr), .job(qj),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_width(rsp.text_width)
   );
endmodule

@@ hdl/ktw_checker.sv @@
module ktw_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_text_width,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_func
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_text_width))
      else $error("result dropped or changed while stalled");
   a_spare_taken: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_func == ktw_pkg::FUNC_SPARE |-> req_ready)
      else $error("unused function transfer not taken at once");
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown straight after reset");
endmodule

bind kerned_text_width_measure_unit ktw_checker u_ktw_checker (
   .clock, .reset, .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_text_width(rsp.text_width), .req_valid(req.valid), .req_ready(req.ready),
   .req_func(req.func)
);
